// File: design/icr_pkg.sv
// Shared types and constants of the interval coverage rate unit.
package icr_pkg;

	localparam int POS_W  = 15;
	localparam int FRAC_W = 16;
	localparam int RATE_W = 17;
	localparam int QUO_W  = POS_W + FRAC_W;

	localparam logic [POS_W-1:0] LEN_RESET = 15'd16384;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CALC,
		ST_RD_A,
		ST_WR_A,
		ST_WR_B,
		ST_SWEEP,
		ST_FLUSH,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} icr_state_t;

endpackage

// File: design/icr_if.sv
// Channel interfaces of the interval coverage rate unit: entries, results, configuration.
interface icr_item_if;
	logic                     valid;
	logic                     ready;
	logic [icr_pkg::POS_W-1:0] ref_start;
	logic [icr_pkg::POS_W-1:0] ref_end;
	logic [icr_pkg::POS_W-1:0] seg_start;
	logic [icr_pkg::POS_W-1:0] seg_end;
	logic [icr_pkg::POS_W-1:0] seg_length;
	logic                     seg_reversed;
	logic                     selected;
	logic                     last_entry;

	modport source (output valid, ref_start, ref_end, seg_start, seg_end, seg_length,
		seg_reversed, selected, last_entry, input ready);
	modport sink (input valid, ref_start, ref_end, seg_start, seg_end, seg_length,
		seg_reversed, selected, last_entry, output ready);
endinterface

interface icr_result_if;
	logic                      valid;
	logic                      ready;
	logic [icr_pkg::POS_W-1:0]  covered_count;
	logic [icr_pkg::RATE_W-1:0] covered_frac;

	modport source (output valid, covered_count, covered_frac, input ready);
	modport sink (input valid, covered_count, covered_frac, output ready);
endinterface

interface icr_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [icr_pkg::POS_W-1:0] ref_length;

	modport source (output valid, ref_length, input ready);
	modport sink (input valid, ref_length, output ready);
endinterface

// File: design/icr_mem.sv
// Difference store: one write port and one read port with registered read data.
module icr_mem #(
	parameter int DEPTH = 16385,
	parameter int AW    = 15,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/icr_div.sv
// Restoring divider that forms floor(count * 2^16 / length), one quotient bit per cycle.
module icr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [icr_pkg::POS_W-1:0]  count,
	input  logic [icr_pkg::POS_W-1:0]  divisor,
	output logic                       done,
	output logic [icr_pkg::RATE_W-1:0] quot
);
	import icr_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [QUO_W-1:0] dvd_q;
	logic [POS_W-1:0] rem_q;
	logic [POS_W-1:0] div_q;
	logic [POS_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The quotient bits shift in behind the dividend bits as they are used up.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= {count, {FRAC_W{1'b0}}};
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? POS_W'(trial - {1'b0, div_q}) : trial[POS_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dvd_q[RATE_W-1:0];

endmodule

// File: design/interval_coverage_rate_unit.sv
// Top level of the interval coverage rate unit: entry marking, sweep and result register.
//
//   channel  dir  beat contents
//   cfg      in   ref_length
//   item     in   ref_start, ref_end, seg_start, seg_end, seg_length, seg_reversed,
//                 selected, last_entry
//   result   out  covered_count, covered_frac
//
// An entry that is skipped or whose marks cancel passes only the step that forms the clamped
// addresses; any other entry adds a read-modify-write on the difference memory for each
// mark. A last entry adds a sweep up to max(L, highest marked address) over the memory's
// single read port, clearing as it goes, then the division and the load of the result
// register.
// After reset a clearing pass over all REF_DEPTH + 1 entries runs before the first entry beat.
// The result sits in an output register, so a stalled result only holds a following
// last entry at the end of its division.
module interval_coverage_rate_unit #(
	parameter int REF_DEPTH   = 16384,
	parameter int COUNT_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	icr_cfg_if.sink      cfg,
	icr_item_if.sink     item,
	icr_result_if.source result
);
	import icr_pkg::*;

	localparam int AW = $clog2(REF_DEPTH + 1);
	localparam int CW = (AW > POS_W) ? AW : POS_W;
	localparam int SW = ((AW > POS_W + 1) ? AW : POS_W + 1) + 2;

	icr_state_t state_q, state_d;

	logic [POS_W-1:0] ref_length_q;
	logic [POS_W-1:0] rs_q, re_q, ss_q, se_q, sl_q;
	logic             rev_q, sel_q, last_q;
	logic [AW-1:0]    a_q, b_q, hi_q, init_idx_q, sw_idx_q, idx_s1;
	logic             valid_s1;
	logic [COUNT_WIDTH-1:0] sum_q;
	logic [POS_W-1:0] cov_q;
	logic             out_valid_q;
	logic [POS_W-1:0] out_count_q;
	logic [RATE_W-1:0] out_rate_q;

	logic [CW-1:0]    len_c;
	logic [AW-1:0]    len_a;
	logic [POS_W-1:0] len_p;
	logic [AW-1:0]    sw_end;

	logic signed [SW-1:0] rs_w, re_w, ss_w, se_w, sl_w, len_w;
	logic signed [SW-1:0] pad_lo, pad_hi, lo_w, hi_w;
	logic [AW-1:0]    a_w, b_w;
	logic             skip_w;

	logic                   mem_rd_en, mem_wr_en;
	logic [AW-1:0]          mem_rd_addr, mem_wr_addr;
	logic [COUNT_WIDTH-1:0] mem_rd_data, mem_wr_data;
	logic [COUNT_WIDTH-1:0] sum_nxt;

	logic              div_start, div_done;
	logic [RATE_W-1:0] div_quot;
	logic              out_load;

	function automatic logic [AW-1:0] clamp_pos(input logic signed [SW-1:0] v,
		input logic signed [SW-1:0] len);
		if (v < 0) begin
			return '0;
		end else if (v > len) begin
			return AW'(len);
		end
		return AW'(v);
	endfunction

	// A length above the memory depth is used as the depth.
	assign len_c = (CW'(ref_length_q) > CW'(REF_DEPTH)) ? CW'(REF_DEPTH) : CW'(ref_length_q);
	assign len_a = AW'(len_c);
	assign len_p = POS_W'(len_c);
	assign sw_end = (len_a > hi_q) ? len_a : hi_q;

	assign rs_w  = $signed({{(SW-POS_W){1'b0}}, rs_q});
	assign re_w  = $signed({{(SW-POS_W){1'b0}}, re_q});
	assign ss_w  = $signed({{(SW-POS_W){1'b0}}, ss_q});
	assign se_w  = $signed({{(SW-POS_W){1'b0}}, se_q});
	assign sl_w  = $signed({{(SW-POS_W){1'b0}}, sl_q});
	assign len_w = $signed({{(SW-AW){1'b0}}, len_a});

	assign pad_lo = rev_q ? (sl_w - se_w) : ss_w;
	assign pad_hi = rev_q ? ss_w : (sl_w - se_w);
	assign lo_w   = ((rs_w > ss_w) ? rs_w : ss_w) - pad_lo;
	assign hi_w   = re_w + pad_hi;
	assign a_w    = clamp_pos(lo_w, len_w);
	assign b_w    = clamp_pos(hi_w, len_w);
	// Marks that land on one entry cancel and leave the store as it is.
	assign skip_w = !sel_q || (a_w == b_w);

	assign sum_nxt  = sum_q + mem_rd_data;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = sw_idx_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = idx_s1;
		mem_wr_data = '0;
		div_start   = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = init_idx_q;
				if (init_idx_q == AW'(REF_DEPTH)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item.valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (!skip_w) begin
					state_d = ST_RD_A;
				end else if (last_q) begin
					state_d = ST_SWEEP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RD_A: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = a_q;
				state_d     = ST_WR_A;
			end
			ST_WR_A: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = a_q;
				mem_wr_data = mem_rd_data + 1'b1;
				mem_rd_en   = 1'b1;
				mem_rd_addr = b_q;
				state_d     = ST_WR_B;
			end
			ST_WR_B: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = b_q;
				mem_wr_data = mem_rd_data - 1'b1;
				state_d     = last_q ? ST_SWEEP : ST_IDLE;
			end
			ST_SWEEP: begin
				mem_rd_en = 1'b1;
				mem_wr_en = valid_s1;
				if (sw_idx_q == sw_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				mem_wr_en = valid_s1;
				state_d   = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_length_q <= LEN_RESET;
			init_idx_q   <= '0;
			sw_idx_q     <= '0;
			valid_s1     <= 1'b0;
			hi_q         <= '0;
			sum_q        <= '0;
			cov_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				ref_length_q <= cfg.ref_length;
			end
			if (state_q == ST_INIT) begin
				init_idx_q <= init_idx_q + 1'b1;
			end
			if (state_q == ST_CALC && !skip_w) begin
				if (a_w > hi_q && a_w >= b_w) begin
					hi_q <= a_w;
				end else if (b_w > hi_q) begin
					hi_q <= b_w;
				end
			end
			if (state_q == ST_SWEEP) begin
				sw_idx_q <= (sw_idx_q == sw_end) ? '0 : sw_idx_q + 1'b1;
			end
			valid_s1 <= (state_q == ST_SWEEP);
			// Entries at or above the length are only cleared, not summed.
			if (valid_s1 && idx_s1 < len_a) begin
				sum_q <= sum_nxt;
				if (sum_nxt != '0 && !sum_nxt[COUNT_WIDTH-1]) begin
					cov_q <= cov_q + 1'b1;
				end
			end
			if (out_load) begin
				hi_q  <= '0;
				sum_q <= '0;
				cov_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item.valid) begin
			rs_q   <= item.ref_start;
			re_q   <= item.ref_end;
			ss_q   <= item.seg_start;
			se_q   <= item.seg_end;
			sl_q   <= item.seg_length;
			rev_q  <= item.seg_reversed;
			sel_q  <= item.selected;
			last_q <= item.last_entry;
		end
		if (state_q == ST_CALC) begin
			a_q <= a_w;
			b_q <= b_w;
		end
		idx_s1 <= sw_idx_q;
		if (out_load) begin
			out_count_q <= cov_q;
			out_rate_q  <= (len_p == '0) ? '0 : div_quot;
		end
	end

	icr_mem #(
		.DEPTH (REF_DEPTH + 1),
		.AW    (AW),
		.DW    (COUNT_WIDTH)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	icr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.count   (cov_q),
		.divisor (len_p),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign cfg.ready            = 1'b1;
	assign item.ready           = (state_q == ST_IDLE);
	assign result.valid         = out_valid_q;
	assign result.covered_count = out_count_q;
	assign result.covered_frac  = out_rate_q;

endmodule

// File: dv/interval_coverage_rate_unit_tb.sv
// Testbench of the interval coverage rate unit: directed and random overlap sets against a coverage predictor.
module interval_coverage_rate_unit_tb;
	import icr_pkg::*;

	localparam int REF_DEPTH   = 16384;
	localparam int COUNT_WIDTH = 16;
	localparam int IDLE_GAP    = 16;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int ITEM_TARGET = 400;
	localparam int POS_MAX     = (1 << POS_W) - 1;

	typedef struct {
		logic [POS_W-1:0] ref_start;
		logic [POS_W-1:0] ref_end;
		logic [POS_W-1:0] seg_start;
		logic [POS_W-1:0] seg_end;
		logic [POS_W-1:0] seg_length;
		logic             seg_reversed;
		logic             selected;
		logic             last_entry;
	} entry_t;

	typedef struct {
		logic [POS_W-1:0]  count;
		logic [RATE_W-1:0] rate;
	} coverage_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	icr_cfg_if    cfg_ch();
	icr_item_if   item_ch();
	icr_result_if result_ch();

	interval_coverage_rate_unit #(
		.REF_DEPTH(REF_DEPTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.item(item_ch),
		.result(result_ch)
	);

	always #5 clk = ~clk;

	// Predictor state: the length register and the difference marks.
	logic [POS_W-1:0]       length_reg;
	logic [COUNT_WIDTH-1:0] diff_marks [0:REF_DEPTH];
	coverage_t              pending_coverage [$];
	coverage_t              want;

	int mismatch_count = 0;
	int items_sent     = 0;
	int burst_left     = 0;
	bit sender_gaps_on = 1'b1;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic int unsigned clamp_to(input int v, input int unsigned len);
		if (v < 0)
			return 0;
		if (v > int'(len))
			return len;
		return unsigned'(v);
	endfunction

	function automatic void apply_entry(input entry_t e);
		int unsigned            len;
		int                     pad_lo;
		int                     pad_hi;
		int                     swap;
		int                     lo;
		int                     hi;
		int unsigned            a;
		int unsigned            b;
		int unsigned            i;
		logic [COUNT_WIDTH-1:0] sum;
		logic [POS_W-1:0]       total;
		longint unsigned        rate;
		len = (length_reg > REF_DEPTH) ? REF_DEPTH : length_reg;
		if (e.selected) begin
			pad_lo = int'(e.seg_start);
			pad_hi = int'(e.seg_length) - int'(e.seg_end);
			if (e.seg_reversed) begin
				swap = pad_lo;
				pad_lo = pad_hi;
				pad_hi = swap;
			end
			lo = ((e.ref_start > e.seg_start) ? int'(e.ref_start) : int'(e.seg_start)) - pad_lo;
			hi = int'(e.ref_end) + pad_hi;
			a = clamp_to(lo, len);
			b = clamp_to(hi, len);
			diff_marks[a] = diff_marks[a] + 1'b1;
			diff_marks[b] = diff_marks[b] - 1'b1;
		end
		if (e.last_entry) begin
			sum = '0;
			total = '0;
			for (i = 0; i < len; i++) begin
				sum = sum + diff_marks[i];
				// Only strictly positive sums count; the sign bit marks a negative stretch.
				if (sum != '0 && !sum[COUNT_WIDTH-1])
					total = total + 1'b1;
			end
			rate = 0;
			if (len != 0)
				rate = (longint'(total) << FRAC_W) / len;
			pending_coverage.push_back('{count: total, rate: rate[RATE_W-1:0]});
			diff_marks = '{default: '0};
		end
	endfunction

	function automatic entry_t mk(input int rs, input int re, input int ss, input int se,
		input int sl, input bit rev, input bit sel, input bit last);
		entry_t e;
		e.ref_start = POS_W'(rs);
		e.ref_end = POS_W'(re);
		e.seg_start = POS_W'(ss);
		e.seg_end = POS_W'(se);
		e.seg_length = POS_W'(sl);
		e.seg_reversed = rev;
		e.selected = sel;
		e.last_entry = last;
		return e;
	endfunction

	// Mostly well-formed overlaps within span, some noise that uses the full field widths.
	function automatic entry_t random_entry(input int unsigned span, input bit last);
		entry_t      e;
		int unsigned sl;
		if ($urandom_range(0, 99) < 12) begin
			e.ref_start = POS_W'($urandom_range(0, POS_MAX));
			e.ref_end = POS_W'($urandom_range(0, POS_MAX));
			e.seg_start = POS_W'($urandom_range(0, POS_MAX));
			e.seg_end = POS_W'($urandom_range(0, POS_MAX));
			e.seg_length = POS_W'($urandom_range(0, POS_MAX));
			e.seg_reversed = 1'($urandom_range(0, 1));
			e.selected = 1'($urandom_range(0, 1));
			e.last_entry = last | ($urandom_range(0, 7) == 0);
			return e;
		end
		e.ref_start = POS_W'($urandom_range(0, span));
		if ($urandom_range(0, 9) == 0)
			e.ref_end = POS_W'($urandom_range(0, e.ref_start));
		else
			e.ref_end = POS_W'($urandom_range(e.ref_start, span));
		sl = $urandom_range(0, span / 2 + 8);
		e.seg_length = POS_W'(sl);
		e.seg_start = POS_W'($urandom_range(0, sl));
		if ($urandom_range(0, 9) == 0)
			e.seg_end = POS_W'(sl + $urandom_range(1, 20));
		else
			e.seg_end = POS_W'($urandom_range(e.seg_start, sl));
		e.seg_reversed = 1'($urandom_range(0, 1));
		e.selected = ($urandom_range(0, 9) != 0);
		e.last_entry = last;
		return e;
	endfunction

	task automatic push_entry(input entry_t e);
		int gap;
		if (burst_left == 0) begin
			gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
			repeat (gap) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.ref_start <= e.ref_start;
		item_ch.ref_end <= e.ref_end;
		item_ch.seg_start <= e.seg_start;
		item_ch.seg_end <= e.seg_end;
		item_ch.seg_length <= e.seg_length;
		item_ch.seg_reversed <= e.seg_reversed;
		item_ch.selected <= e.selected;
		item_ch.last_entry <= e.last_entry;
		do @(posedge clk); while (!item_ch.ready);
		apply_entry(e);
		items_sent++;
	endtask

	// Holds the entry channel until every expected result has come and the block has settled.
	task automatic wait_idle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_coverage.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_ref_length(input logic [POS_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.ref_length <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		length_reg = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_set(input int unsigned span, input int count);
		int k;
		for (k = 0; k < count; k++)
			push_entry(random_entry(span, k == count - 1));
	endtask

	function automatic int unsigned span_for(input logic [POS_W-1:0] len);
		int unsigned eff;
		eff = (len > REF_DEPTH) ? REF_DEPTH : len;
		// Reach a little past the reference so the clamps are exercised.
		return (eff == 0) ? 40 : eff + eff / 4 + 4;
	endfunction

	// Runs at the reset length of 16384.
	task automatic test_directed_marks();
		// Plain forward overlap, then a start padding larger than the start, plain and reversed.
		push_entry(mk(10, 50, 0, 40, 40, 1'b0, 1'b1, 1'b0));
		push_entry(mk(5, 20, 30, 45, 100, 1'b0, 1'b1, 1'b0));
		push_entry(mk(5, 20, 30, 45, 100, 1'b1, 1'b1, 1'b1));
		// Segment end past its length gives a start past the end, under a positive cover.
		push_entry(mk(100, 200, 0, 300, 50, 1'b0, 1'b1, 1'b0));
		push_entry(mk(60, 400, 0, 10, 10, 1'b0, 1'b1, 1'b0));
		push_entry(mk(16000, 16384, 0, 10, 5000, 1'b0, 1'b1, 1'b1));
		// Every field at its top value, both orientations.
		push_entry(mk(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b1, 1'b0));
		push_entry(mk(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b1, 1'b1, 1'b1));
		// A skipped entry, then a skipped last entry that still sweeps.
		push_entry(mk(0, 16384, 0, 0, 0, 1'b0, 1'b0, 1'b0));
		push_entry(mk(0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b1));
		// Full coverage gives the top rate.
		push_entry(mk(0, 16384, 0, 0, 0, 1'b0, 1'b1, 1'b1));
	endtask

	task automatic test_length_settings();
		logic [POS_W-1:0] lengths [6];
		int               n;
		lengths = '{15'd0, 15'd1, 15'd2, 15'd32767, 15'd20000, 15'd16384};
		for (n = 0; n < 6; n++) begin
			write_ref_length(lengths[n]);
			send_set(span_for(lengths[n]), 3);
		end
	endtask

	task automatic test_random_sets();
		int          pick;
		int unsigned len;
		int          sets;
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)
				len = $urandom_range(65, 1024);
			else
				len = $urandom_range(1, 64);
			sender_gaps_on = ($urandom_range(0, 3) != 0);
			write_ref_length(POS_W'(len));
			sets = $urandom_range(2, 6);
			repeat (sets) begin
				send_set(span_for(POS_W'(len)), $urandom_range(1, 8));
				if ($urandom_range(0, 4) == 0)
					wait_idle();
			end
		end
	endtask

	logic [7:0] stall_pattern = 8'hFF;
	int         stall_left = 0;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			if ($urandom_range(0, 2) == 0)
				stall_pattern = 8'hFF;
			else
				stall_pattern = 8'($urandom_range(0, 255)) | 8'h01;
			stall_left = $urandom_range(16, 160);
		end
		stall_left--;
		result_ch.ready <= stall_pattern[0];
		stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_coverage.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected: count %0d rate %0d",
					result_ch.covered_count, result_ch.covered_frac));
			end else begin
				want = pending_coverage.pop_front();
				if (result_ch.covered_count !== want.count)
					report_mismatch($sformatf("covered_count %0d, expected %0d",
						result_ch.covered_count, want.count));
				if (result_ch.covered_frac !== want.rate)
					report_mismatch($sformatf("covered_frac %0d, expected %0d",
						result_ch.covered_frac, want.rate));
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("interval_coverage_rate_unit_tb failed");
		$finish;
	end

	initial begin
		length_reg = LEN_RESET;
		diff_marks = '{default: '0};
		item_ch.valid = 1'b0;
		item_ch.ref_start = '0;
		item_ch.ref_end = '0;
		item_ch.seg_start = '0;
		item_ch.seg_end = '0;
		item_ch.seg_length = '0;
		item_ch.seg_reversed = 1'b0;
		item_ch.selected = 1'b0;
		item_ch.last_entry = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.ref_length = '0;
		result_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_marks();
		test_length_settings();
		test_random_sets();

		wait_idle();
		repeat (40) @(posedge clk);
		if (pending_coverage.size() != 0)
			report_mismatch("expected results left over at the end");
		if (mismatch_count == 0) begin
			$display("interval_coverage_rate_unit_tb passed");
		end else begin
			$display("interval_coverage_rate_unit_tb failed");
		end
		$finish;
	end

endmodule
